[hw/rtl/ffsa_pkg.sv]
`timescale 1ns / 1ps

package ffsa_pkg;

    // Table geometry
    localparam int MAX_SEGMENTS = 16;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

    // Field widths
    localparam int ID_W    = 32;
    localparam int ADDR_W  = 20;
    localparam int LIMIT_W = 21;
    localparam int COUNT_W = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_MAX = 21'h10_0000;
    localparam logic [CNT_W-1:0]   CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(MAX_SEGMENTS);

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // One table entry
    typedef struct packed {
        logic [ID_W-1:0]   seg_id;
        logic [ADDR_W-1:0] seg_start;
        logic [ADDR_W-1:0] seg_end;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALLOC_SCAN,
        ST_CHECK,
        ST_SHIFT_UP,
        ST_PLACE,
        ST_FREE_SCAN,
        ST_FREE_HIT,
        ST_SHIFT_DOWN,
        ST_REMOVE,
        ST_FAIL
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_alloc;
        logic scan_free;
        logic check;
        logic free_hit;
        logic shift_up;
        logic shift_down;
        logic place;
        logic remove;
        logic fail;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pre_fail;
        logic tbl_empty;
        logic scan_hit;
        logic scan_last;
        logic fit_ok;
        logic pos_at_end;
        logic free_at_end;
        logic shift_done;
    } t_status;

endpackage

[hw/rtl/ffsa_ram.sv]
`timescale 1ns / 1ps

module ffsa_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/ffsa_ctrl.sv]
`timescale 1ns / 1ps

module ffsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_op,
    input  ffsa_pkg::t_status i_status,
    output logic              o_busy,
    output ffsa_pkg::t_cmd    o_cmd
);

    ffsa_pkg::t_state r_state;
    ffsa_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffsa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffsa_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_op == ffsa_pkg::OP_ALLOC) begin
                        if (i_status.pre_fail) begin
                            n_state = ffsa_pkg::ST_FAIL;
                        end else if (i_status.tbl_empty) begin
                            n_state = ffsa_pkg::ST_CHECK;
                        end else begin
                            n_state = ffsa_pkg::ST_ALLOC_SCAN;
                        end
                    end else begin
                        if (i_status.tbl_empty) begin
                            n_state = ffsa_pkg::ST_FAIL;
                        end else begin
                            n_state = ffsa_pkg::ST_FREE_SCAN;
                        end
                    end
                end
            end
            ffsa_pkg::ST_ALLOC_SCAN: begin
                if (i_status.scan_hit || i_status.scan_last) begin
                    n_state = ffsa_pkg::ST_CHECK;
                end
            end
            ffsa_pkg::ST_CHECK: begin
                if (!i_status.fit_ok) begin
                    n_state = ffsa_pkg::ST_FAIL;
                end else if (i_status.pos_at_end) begin
                    n_state = ffsa_pkg::ST_PLACE;
                end else begin
                    n_state = ffsa_pkg::ST_SHIFT_UP;
                end
            end
            ffsa_pkg::ST_SHIFT_UP: begin
                if (i_status.shift_done) begin
                    n_state = ffsa_pkg::ST_PLACE;
                end
            end
            ffsa_pkg::ST_PLACE: begin
                n_state = ffsa_pkg::ST_IDLE;
            end
            ffsa_pkg::ST_FREE_SCAN: begin
                if (i_status.scan_hit) begin
                    n_state = ffsa_pkg::ST_FREE_HIT;
                end else if (i_status.scan_last) begin
                    n_state = ffsa_pkg::ST_FAIL;
                end
            end
            ffsa_pkg::ST_FREE_HIT: begin
                if (i_status.free_at_end) begin
                    n_state = ffsa_pkg::ST_REMOVE;
                end else begin
                    n_state = ffsa_pkg::ST_SHIFT_DOWN;
                end
            end
            ffsa_pkg::ST_SHIFT_DOWN: begin
                if (i_status.shift_done) begin
                    n_state = ffsa_pkg::ST_REMOVE;
                end
            end
            ffsa_pkg::ST_REMOVE: begin
                n_state = ffsa_pkg::ST_IDLE;
            end
            ffsa_pkg::ST_FAIL: begin
                n_state = ffsa_pkg::ST_IDLE;
            end
            default: begin
                n_state = ffsa_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ffsa_pkg::ST_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_start;
            end
            ffsa_pkg::ST_ALLOC_SCAN: o_cmd.scan_alloc = 1'b1;
            ffsa_pkg::ST_CHECK:      o_cmd.check      = 1'b1;
            ffsa_pkg::ST_SHIFT_UP:   o_cmd.shift_up   = 1'b1;
            ffsa_pkg::ST_PLACE:      o_cmd.place      = 1'b1;
            ffsa_pkg::ST_FREE_SCAN:  o_cmd.scan_free  = 1'b1;
            ffsa_pkg::ST_FREE_HIT:   o_cmd.free_hit   = 1'b1;
            ffsa_pkg::ST_SHIFT_DOWN: o_cmd.shift_down = 1'b1;
            ffsa_pkg::ST_REMOVE:     o_cmd.remove     = 1'b1;
            ffsa_pkg::ST_FAIL:       o_cmd.fail       = 1'b1;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[hw/rtl/ffsa_dp.sv]
`timescale 1ns / 1ps

module ffsa_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ffsa_pkg::LIMIT_W-1:0]       i_cfg_wdata,
    input  logic                               i_op,
    input  logic [ffsa_pkg::ID_W-1:0]          i_amount_or_id,
    input  ffsa_pkg::t_cmd                     i_cmd,
    output ffsa_pkg::t_status                  o_status,
    output logic                               o_done,
    output logic                               o_ok,
    output logic [ffsa_pkg::ID_W-1:0]          o_block_id,
    output logic [ffsa_pkg::ADDR_W-1:0]        o_start_addr,
    output logic [ffsa_pkg::ADDR_W-1:0]        o_end_addr,
    output logic [ffsa_pkg::LIMIT_W-1:0]       o_used_bytes,
    output logic [ffsa_pkg::COUNT_W-1:0]       o_segment_count,
    output logic                               o_fits_budget
);

    // Control state
    logic [ffsa_pkg::LIMIT_W-1:0] r_limit, n_limit;
    logic [ffsa_pkg::CNT_W-1:0]   r_total, n_total;
    logic [ffsa_pkg::LIMIT_W-1:0] r_bytes, n_bytes;
    logic [ffsa_pkg::ID_W-1:0]    r_next_id, n_next_id;
    logic                         r_rd_live, n_rd_live;
    logic                         r_dat_vld, n_dat_vld;
    logic                         r_done, n_done;

    // Working and result registers
    logic [ffsa_pkg::ID_W-1:0]    r_arg, n_arg;
    logic                         r_fits, n_fits;
    logic [ffsa_pkg::CNT_W-1:0]   r_rd_idx, n_rd_idx;
    logic [ffsa_pkg::CNT_W-1:0]   r_dat_idx, n_dat_idx;
    logic [ffsa_pkg::ADDR_W-1:0]  r_prev_end, n_prev_end;
    logic [ffsa_pkg::LIMIT_W-1:0] r_cand, n_cand;
    logic [ffsa_pkg::CNT_W-1:0]   r_pos, n_pos;
    ffsa_pkg::t_entry             r_hit, n_hit;
    logic                         r_ok, n_ok;
    logic [ffsa_pkg::ID_W-1:0]    r_id, n_id;
    logic [ffsa_pkg::ADDR_W-1:0]  r_start, n_start;
    logic [ffsa_pkg::ADDR_W-1:0]  r_end, n_end;
    logic [ffsa_pkg::LIMIT_W-1:0] r_used, n_used;
    logic [ffsa_pkg::COUNT_W-1:0] r_count, n_count;
    logic                         r_fits_out, n_fits_out;

    // Table RAM port
    logic                          ram_we;
    logic [ffsa_pkg::IDX_W-1:0]    ram_waddr;
    ffsa_pkg::t_entry              ram_wdata;
    logic [ffsa_pkg::ENTRY_W-1:0]  ram_rdata;
    ffsa_pkg::t_entry              rd;

    // Helpers
    logic                          rd_issue;
    logic [ffsa_pkg::CNT_W-1:0]    last_idx;
    logic [ffsa_pkg::CNT_W-1:0]    dat_idx_inc;
    logic [ffsa_pkg::CNT_W-1:0]    dat_idx_dec;
    logic [ffsa_pkg::CNT_W-1:0]    total_inc;
    logic [ffsa_pkg::CNT_W-1:0]    total_dec;
    logic                          dat_last;
    logic [ffsa_pkg::LIMIT_W-1:0]  gap;
    logic                          gap_big;
    logic                          first_hit;
    logic                          alloc_hit;
    logic                          free_hit;
    logic [32:0]                   budget_sum;
    logic [32:0]                   tail_sum;
    logic                          fit_ok;
    logic [ffsa_pkg::ADDR_W-1:0]   new_end;
    logic [ffsa_pkg::LIMIT_W-1:0]  hit_size;
    logic [ffsa_pkg::LIMIT_W-1:0]  cfg_limit;
    logic [ffsa_pkg::CNT_W+ffsa_pkg::COUNT_W-1:0] cnt_ext;

    ffsa_ram #(
        .WIDTH (ffsa_pkg::ENTRY_W),
        .DEPTH (ffsa_pkg::MAX_SEGMENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx[ffsa_pkg::IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd = ffsa_pkg::t_entry'(ram_rdata);

    // Index arithmetic
    assign last_idx    = r_total - ffsa_pkg::CNT_ONE;
    assign dat_idx_inc = r_dat_idx + ffsa_pkg::CNT_ONE;
    assign dat_idx_dec = r_dat_idx - ffsa_pkg::CNT_ONE;
    assign total_inc   = r_total + ffsa_pkg::CNT_ONE;
    assign total_dec   = r_total - ffsa_pkg::CNT_ONE;
    assign dat_last    = (r_dat_idx == last_idx);

    // First-fit compares on the word just read
    assign gap       = {1'b0, rd.seg_start} - {1'b0, r_prev_end};
    assign gap_big   = gap[ffsa_pkg::LIMIT_W-1] || ({11'b0, gap} > r_arg);
    assign first_hit = (r_dat_idx == '0) && ({12'b0, rd.seg_start} >= r_arg);
    assign alloc_hit = r_dat_vld && (first_hit || ((r_dat_idx != '0) && gap_big));
    assign free_hit  = r_dat_vld && (rd.seg_id == r_arg);

    // Budget check at accept, tail check of the chosen gap
    assign budget_sum = {12'b0, r_bytes} + {1'b0, i_amount_or_id};
    assign tail_sum   = {12'b0, r_cand} + {1'b0, r_arg};
    assign fit_ok     = (tail_sum <= {12'b0, r_limit});

    assign new_end   = r_cand[ffsa_pkg::ADDR_W-1:0] + r_arg[ffsa_pkg::ADDR_W-1:0]
                     - 20'd1;
    assign hit_size  = {1'b0, r_hit.seg_end - r_hit.seg_start} + 21'd1;
    assign cfg_limit = (i_cfg_wdata > ffsa_pkg::LIMIT_MAX) ? ffsa_pkg::LIMIT_MAX
                                                           : i_cfg_wdata;

    // Status to the controller
    always_comb begin
        o_status             = '0;
        o_status.pre_fail    = (i_amount_or_id == '0) || (r_total == ffsa_pkg::CNT_FULL);
        o_status.tbl_empty   = (r_total == '0);
        o_status.scan_hit    = i_cmd.scan_alloc ? alloc_hit : free_hit;
        o_status.scan_last   = r_dat_vld && dat_last;
        o_status.fit_ok      = fit_ok;
        o_status.pos_at_end  = (r_pos == r_total);
        o_status.free_at_end = (r_pos == last_idx);
        o_status.shift_done  = i_cmd.shift_up ? (r_dat_vld && (r_dat_idx == r_pos))
                                              : (r_dat_vld && dat_last);
    end

    // Next-state logic of the datapath
    always_comb begin
        n_limit    = r_limit;
        n_total    = r_total;
        n_bytes    = r_bytes;
        n_next_id  = r_next_id;
        n_rd_live  = r_rd_live;
        n_done     = 1'b0;
        n_arg      = r_arg;
        n_fits     = r_fits;
        n_rd_idx   = r_rd_idx;
        n_dat_idx  = r_rd_idx;
        n_prev_end = r_prev_end;
        n_cand     = r_cand;
        n_pos      = r_pos;
        n_hit      = r_hit;
        n_ok       = r_ok;
        n_id       = r_id;
        n_start    = r_start;
        n_end      = r_end;
        n_used     = r_used;
        n_fits_out = r_fits_out;
        ram_we     = 1'b0;
        ram_waddr  = r_pos[ffsa_pkg::IDX_W-1:0];
        ram_wdata  = rd;
        rd_issue   = 1'b0;
        cnt_ext    = {{ffsa_pkg::COUNT_W{1'b0}}, r_total};

        // Read issue: ascending walks stop at the table end
        if (i_cmd.scan_alloc || i_cmd.scan_free || i_cmd.shift_down) begin
            rd_issue = (r_rd_idx < r_total);
            if (rd_issue) begin
                n_rd_idx = r_rd_idx + ffsa_pkg::CNT_ONE;
            end
        end
        // Descending walk stops after the insert position
        if (i_cmd.shift_up) begin
            rd_issue = r_rd_live;
            if (rd_issue) begin
                n_rd_idx  = r_rd_idx - ffsa_pkg::CNT_ONE;
                n_rd_live = (r_rd_idx != r_pos);
            end
        end
        n_dat_vld = rd_issue;

        if (i_cfg_we) begin
            n_limit = cfg_limit;
        end

        if (i_cmd.accept) begin
            n_arg    = i_amount_or_id;
            n_fits   = (i_op == ffsa_pkg::OP_ALLOC) && (budget_sum <= {12'b0, r_limit});
            n_rd_idx = '0;
            n_cand   = '0;
            n_pos    = '0;
        end

        // Gap search
        if (i_cmd.scan_alloc && r_dat_vld) begin
            n_prev_end = rd.seg_end;
            if (alloc_hit) begin
                n_cand = first_hit ? '0 : ({1'b0, r_prev_end} + 21'd1);
                n_pos  = r_dat_idx;
            end else if (dat_last) begin
                n_cand = {1'b0, rd.seg_end} + 21'd1;
                n_pos  = r_total;
            end
        end

        // Id search
        if (i_cmd.scan_free && free_hit) begin
            n_pos = r_dat_idx;
            n_hit = rd;
        end

        if (i_cmd.check) begin
            n_rd_idx  = last_idx;
            n_rd_live = 1'b1;
        end

        if (i_cmd.free_hit) begin
            n_rd_idx = r_pos + ffsa_pkg::CNT_ONE;
        end

        // Open a hole at the insert position
        if (i_cmd.shift_up && r_dat_vld) begin
            ram_we    = 1'b1;
            ram_waddr = dat_idx_inc[ffsa_pkg::IDX_W-1:0];
        end

        // Close the hole of the freed entry
        if (i_cmd.shift_down && r_dat_vld) begin
            ram_we    = 1'b1;
            ram_waddr = dat_idx_dec[ffsa_pkg::IDX_W-1:0];
        end

        if (i_cmd.place) begin
            ram_we              = 1'b1;
            ram_waddr           = r_pos[ffsa_pkg::IDX_W-1:0];
            ram_wdata.seg_id    = r_next_id;
            ram_wdata.seg_start = r_cand[ffsa_pkg::ADDR_W-1:0];
            ram_wdata.seg_end   = new_end;
            n_total    = total_inc;
            n_bytes    = r_bytes + r_arg[ffsa_pkg::LIMIT_W-1:0];
            n_next_id  = r_next_id + 32'd1;
            n_done     = 1'b1;
            n_ok       = 1'b1;
            n_id       = r_next_id;
            n_start    = r_cand[ffsa_pkg::ADDR_W-1:0];
            n_end      = new_end;
            n_used     = r_bytes + r_arg[ffsa_pkg::LIMIT_W-1:0];
            cnt_ext    = {{ffsa_pkg::COUNT_W{1'b0}}, total_inc};
            n_fits_out = r_fits;
        end

        if (i_cmd.remove) begin
            n_total    = total_dec;
            n_bytes    = r_bytes - hit_size;
            n_done     = 1'b1;
            n_ok       = 1'b1;
            n_id       = r_hit.seg_id;
            n_start    = r_hit.seg_start;
            n_end      = r_hit.seg_end;
            n_used     = r_bytes - hit_size;
            cnt_ext    = {{ffsa_pkg::COUNT_W{1'b0}}, total_dec};
            n_fits_out = r_fits;
        end

        if (i_cmd.fail) begin
            n_done     = 1'b1;
            n_ok       = 1'b0;
            n_id       = '0;
            n_start    = '0;
            n_end      = '0;
            n_used     = r_bytes;
            n_fits_out = r_fits;
        end

        n_count = cnt_ext[ffsa_pkg::COUNT_W-1:0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= ffsa_pkg::LIMIT_MAX;
            r_total   <= '0;
            r_bytes   <= '0;
            r_next_id <= 32'd1;
            r_rd_live <= 1'b0;
            r_dat_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_limit   <= n_limit;
            r_total   <= n_total;
            r_bytes   <= n_bytes;
            r_next_id <= n_next_id;
            r_rd_live <= n_rd_live;
            r_dat_vld <= n_dat_vld;
            r_done    <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_arg      <= n_arg;
        r_fits     <= n_fits;
        r_rd_idx   <= n_rd_idx;
        r_dat_idx  <= n_dat_idx;
        r_prev_end <= n_prev_end;
        r_cand     <= n_cand;
        r_pos      <= n_pos;
        r_hit      <= n_hit;
        r_ok       <= n_ok;
        r_id       <= n_id;
        r_start    <= n_start;
        r_end      <= n_end;
        r_used     <= n_used;
        r_count    <= n_count;
        r_fits_out <= n_fits_out;
    end

    assign o_done          = r_done;
    assign o_ok            = r_ok;
    assign o_block_id      = r_id;
    assign o_start_addr    = r_start;
    assign o_end_addr      = r_end;
    assign o_used_bytes    = r_used;
    assign o_segment_count = r_count;
    assign o_fits_budget   = r_fits_out;

endmodule

[hw/rtl/first_fit_segment_allocator.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Word
// request   in         start, busy          i_op, i_amount_or_id
// result    out        o_done (one cycle)   o_ok, o_block_id, o_start_addr, o_end_addr,
//                                           o_used_bytes, o_segment_count, o_fits_budget
// config    in         i_cfg_we             i_cfg_wdata (memory limit, saturated)
//
// One request at a time; busy is high from the accepting edge until the result cycle.
// Allocate scans k entries to the gap, then moves m entries up to open a hole.
// Free scans k entries to the id, then moves m entries down to close its hole.
// The single read port of the table RAM, one entry per cycle, sets the pace. Reset is
// synchronous and needs no sweep. The receiver cannot stall: o_done marks the result
// for exactly one cycle.

module first_fit_segment_allocator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_op,
    input  logic [ffsa_pkg::ID_W-1:0]          i_amount_or_id,
    input  logic                               i_cfg_we,
    input  logic [ffsa_pkg::LIMIT_W-1:0]       i_cfg_wdata,
    output logic                               o_done,
    output logic                               o_ok,
    output logic [ffsa_pkg::ID_W-1:0]          o_block_id,
    output logic [ffsa_pkg::ADDR_W-1:0]        o_start_addr,
    output logic [ffsa_pkg::ADDR_W-1:0]        o_end_addr,
    output logic [ffsa_pkg::LIMIT_W-1:0]       o_used_bytes,
    output logic [ffsa_pkg::COUNT_W-1:0]       o_segment_count,
    output logic                               o_fits_budget
);

    ffsa_pkg::t_cmd    cmd;
    ffsa_pkg::t_status status;

    ffsa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_op),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    ffsa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_op            (i_op),
        .i_amount_or_id  (i_amount_or_id),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_done          (o_done),
        .o_ok            (o_ok),
        .o_block_id      (o_block_id),
        .o_start_addr    (o_start_addr),
        .o_end_addr      (o_end_addr),
        .o_used_bytes    (o_used_bytes),
        .o_segment_count (o_segment_count),
        .o_fits_budget   (o_fits_budget)
    );

    // A result only shows once the controller is back in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // An accepted request makes the block busy in the following cycle, with no result yet
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("request accepted without going busy");

    // Failed requests report id zero
    a_fail_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |-> (o_block_id == '0))
        else $error("failed request with nonzero id");

    // A reported segment never ends before it starts
    a_seg_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_ok) |-> (o_end_addr >= o_start_addr))
        else $error("segment end below start");

endmodule

[test/tb_first_fit_segment_allocator.sv]
`timescale 1ns / 1ps

module tb_first_fit_segment_allocator;

    localparam int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS;
    localparam int ID_W         = ffsa_pkg::ID_W;
    localparam int ADDR_W       = ffsa_pkg::ADDR_W;
    localparam int LIMIT_W      = ffsa_pkg::LIMIT_W;
    localparam int COUNT_W      = ffsa_pkg::COUNT_W;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = ffsa_pkg::LIMIT_MAX;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 10;
    localparam int PHASE_WORDS  = 113;
    localparam int DRAIN_CYCLES = 2 * MAX_SEGMENTS + 16;

    // One result word as the block reports it
    typedef struct {
        logic                 ok;
        logic [ID_W-1:0]      block_id;
        logic [ADDR_W-1:0]    start_addr;
        logic [ADDR_W-1:0]    end_addr;
        logic [LIMIT_W-1:0]   used_bytes;
        logic [COUNT_W-1:0]   segment_count;
        logic                 fits_budget;
    } t_alloc_result;

    // Shadow of the segment table plus the queue of results still owed
    class alloc_scoreboard;
        ffsa_pkg::t_entry seg_q[$];     // sorted by start address
        longint unsigned used;
        logic [ID_W-1:0] next_id;
        logic [LIMIT_W-1:0] limit;
        t_alloc_result   owed_q[$];
        int              errors;
        int              n_placed;
        int              n_freed;
        int              n_refused;
        int              n_checked;

        function new();
            used    = 0;
            next_id = 1;
            limit   = LIMIT_MAX;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] value);
            limit = (value > LIMIT_MAX) ? LIMIT_MAX : value;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function logic [ID_W-1:0] pick_live_id();
            if (seg_q.size() == 0)
                return ID_W'($urandom_range(0, 40));
            return seg_q[$urandom_range(0, seg_q.size() - 1)].seg_id;
        endfunction

        // Work out the result of one accepted request and update the shadow
        function void note_request(logic op, logic [ID_W-1:0] arg);
            t_alloc_result    r;
            longint unsigned  base;
            int               slot;
            ffsa_pkg::t_entry e;
            r = '{default: '0};
            if (op == ffsa_pkg::OP_ALLOC) begin
                r.fits_budget = (used + 64'(arg) <= 64'(limit));
                if (arg != 0 && seg_q.size() < MAX_SEGMENTS) begin
                    base = 0;
                    slot = 0;
                    // first fit: below the first segment, between neighbors, then the tail
                    if (seg_q.size() != 0 && 64'(seg_q[0].seg_start) < 64'(arg)) begin
                        slot = seg_q.size();
                        base = 64'(seg_q[slot - 1].seg_end) + 1;
                        for (int k = 0; k + 1 < seg_q.size(); k++) begin
                            if (64'(seg_q[k + 1].seg_start) - 64'(seg_q[k].seg_end)
                                > 64'(arg)) begin
                                base = 64'(seg_q[k].seg_end) + 1;
                                slot = k + 1;
                                break;
                            end
                        end
                    end
                    if (base + 64'(arg) <= 64'(limit)) begin
                        e.seg_id    = next_id;
                        e.seg_start = ADDR_W'(base);
                        e.seg_end   = ADDR_W'(base + 64'(arg) - 1);
                        seg_q.insert(slot, e);
                        used         = used + 64'(arg);
                        next_id      = next_id + 1;
                        r.ok         = 1'b1;
                        r.block_id   = e.seg_id;
                        r.start_addr = e.seg_start;
                        r.end_addr   = e.seg_end;
                    end
                end
            end else begin
                // lowest start wins if an id were ever shared
                for (int k = 0; k < seg_q.size(); k++) begin
                    if (seg_q[k].seg_id == arg) begin
                        e            = seg_q[k];
                        used         = used - (64'(e.seg_end) - 64'(e.seg_start) + 1);
                        seg_q.delete(k);
                        r.ok         = 1'b1;
                        r.block_id   = e.seg_id;
                        r.start_addr = e.seg_start;
                        r.end_addr   = e.seg_end;
                        break;
                    end
                end
            end
            r.used_bytes    = LIMIT_W'(used);
            r.segment_count = COUNT_W'(seg_q.size());
            if (r.ok && op == ffsa_pkg::OP_ALLOC)
                n_placed++;
            else if (r.ok)
                n_freed++;
            else
                n_refused++;
            owed_q.insert(owed_q.size(), r);
        endfunction

        function void field_check(string label, longint unsigned want, longint unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, label, want, got);
            end
        endfunction

        function void check_result(t_alloc_result got);
            t_alloc_result want;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing owed: ok=%0b id=0x%0h",
                         $time, got.ok, got.block_id);
                return;
            end
            want = owed_q.pop_front();
            n_checked++;
            field_check("ok", want.ok, got.ok);
            field_check("block_id", want.block_id, got.block_id);
            field_check("start_addr", want.start_addr, got.start_addr);
            field_check("end_addr", want.end_addr, got.end_addr);
            field_check("used_bytes", want.used_bytes, got.used_bytes);
            field_check("segment_count", want.segment_count, got.segment_count);
            field_check("fits_budget", want.fits_budget, got.fits_budget);
        endfunction

        function void flush_leftovers();
            while (owed_q.size() != 0) begin
                errors++;
                $display("%0t: result never seen: expected ok=%0b id=0x%0h, actual none",
                         $time, owed_q[0].ok, owed_q[0].block_id);
                void'(owed_q.pop_front());
            end
        endfunction
    endclass

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 start          = 1'b0;
    logic                 i_op           = ffsa_pkg::OP_ALLOC;
    logic [ID_W-1:0]      i_amount_or_id = '0;
    logic                 i_cfg_we       = 1'b0;
    logic [LIMIT_W-1:0]   i_cfg_wdata    = '0;
    logic                 busy;
    logic                 o_done;
    logic                 o_ok;
    logic [ID_W-1:0]      o_block_id;
    logic [ADDR_W-1:0]    o_start_addr;
    logic [ADDR_W-1:0]    o_end_addr;
    logic [LIMIT_W-1:0]   o_used_bytes;
    logic [COUNT_W-1:0]   o_segment_count;
    logic                 o_fits_budget;

    alloc_scoreboard      sb;
    t_alloc_result        seen_word;
    int                   cycle_count = 0;

    first_fit_segment_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_amount_or_id  (i_amount_or_id),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_done          (o_done),
        .o_ok            (o_ok),
        .o_block_id      (o_block_id),
        .o_start_addr    (o_start_addr),
        .o_end_addr      (o_end_addr),
        .o_used_bytes    (o_used_bytes),
        .o_segment_count (o_segment_count),
        .o_fits_budget   (o_fits_budget)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_first_fit_segment_allocator: errors");
            $finish;
        end
    end

    // Result monitor: the strobe lasts one cycle, take the word at its closing edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            seen_word.ok            = o_ok;
            seen_word.block_id      = o_block_id;
            seen_word.start_addr    = o_start_addr;
            seen_word.end_addr      = o_end_addr;
            seen_word.used_bytes    = o_used_bytes;
            seen_word.segment_count = o_segment_count;
            seen_word.fits_budget   = o_fits_budget;
            sb.check_result(seen_word);
        end
    end

    // Present one request and hold it until the accepting edge
    task automatic send_request(input logic op, input logic [ID_W-1:0] arg);
        start          <= 1'b1;
        i_op           <= op;
        i_amount_or_id <= arg;
        do
            @(posedge i_clk);
        while (busy);
        sb.note_request(op, arg);
    endtask

    // Random burst of sender idle cycles
    task automatic sender_gap();
        start <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge i_clk);
    endtask

    // Hold off until every owed result has come and the block is idle
    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending() != 0 || busy)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_limit(value);
    endtask

    // Request size: mostly small against the limit, some zero, oversize or huge
    function automatic logic [ID_W-1:0] pick_size(logic [LIMIT_W-1:0] lim);
        int unsigned roll;
        int unsigned cap;
        roll = $urandom_range(0, 99);
        cap  = (lim / 12 > 1) ? lim / 12 : 1;
        if (roll < 4)
            return '0;
        if (roll < 9)
            return $urandom();
        if (roll < 16)
            return ID_W'($urandom_range(0, lim + 1));
        return ID_W'($urandom_range(1, cap));
    endfunction

    // Stimulus
    initial begin
        logic [LIMIT_W-1:0] phase_limit [PHASES];
        logic [LIMIT_W-1:0] lim;
        int unsigned        roll;
        bit                 quiet;

        sb = new();
        phase_limit = '{21'h1F_FFFF, 21'd64, 21'd0, 21'd1, 21'd1000, LIMIT_MAX,
                        LIMIT_W'($urandom_range(2, LIMIT_MAX)), 21'd300,
                        LIMIT_MAX + 21'd1, 21'd4096};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero size, unknown id, huge size, exact fill of memory
        send_request(ffsa_pkg::OP_ALLOC, 32'd0);
        send_request(ffsa_pkg::OP_FREE, 32'hFFFF_FFFF);
        send_request(ffsa_pkg::OP_ALLOC, 32'd1);
        send_request(ffsa_pkg::OP_ALLOC, 32'hFFFF_FFFF);
        send_request(ffsa_pkg::OP_ALLOC, 32'(LIMIT_MAX - 1));
        send_request(ffsa_pkg::OP_FREE, 32'd1);
        // gap below the first segment
        send_request(ffsa_pkg::OP_ALLOC, 32'd1);
        send_request(ffsa_pkg::OP_FREE, 32'd2);
        // fill the table, then one too many
        repeat (MAX_SEGMENTS - 1) send_request(ffsa_pkg::OP_ALLOC, 32'd8);
        send_request(ffsa_pkg::OP_ALLOC, 32'd8);
        // open a hole between neighbors and refill it exactly
        send_request(ffsa_pkg::OP_FREE, 32'd8);
        send_request(ffsa_pkg::OP_ALLOC, 32'd8);
        wait_drained();

        // Random phases, one memory limit each; no idling in the last one
        for (int p = 0; p < PHASES; p++) begin
            quiet = (p == PHASES - 1);
            write_limit(phase_limit[p]);
            lim = sb.limit;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 52)
                    send_request(ffsa_pkg::OP_ALLOC, pick_size(lim));
                else if (roll < 90)
                    send_request(ffsa_pkg::OP_FREE, sb.pick_live_id());
                else if (roll < 95)
                    send_request(ffsa_pkg::OP_FREE, $urandom());
                else
                    send_request(ffsa_pkg::OP_FREE, ID_W'($urandom_range(0, 2000)));
                if (!quiet) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3)
                        wait_drained();
                    else if (roll < 28)
                        sender_gap();
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.flush_leftovers();

        $display("covered %0d results under %0d memory limits plus the reset value",
                 sb.n_checked, PHASES);
        $display("%0d segments placed, %0d freed, %0d requests refused",
                 sb.n_placed, sb.n_freed, sb.n_refused);
        if (sb.errors == 0)
            $display("tb_first_fit_segment_allocator: clean");
        else
            $display("tb_first_fit_segment_allocator: errors");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/ffsa_pkg.sv
hw/rtl/ffsa_ram.sv
hw/rtl/ffsa_ctrl.sv
hw/rtl/ffsa_dp.sv
hw/rtl/first_fit_segment_allocator.sv
test/tb_first_fit_segment_allocator.sv
